// File: sv/oaid_pkg.sv
// oaid_pkg: shared types and codes for the ordered array insert/delete block
// used by oaid_if.sv, oaid_cell.sv and ordered_array_insert_delete.sv
`timescale 1ns / 1ps

package oaid_pkg;

   // default and largest capacity of the list
   localparam int DEPTH_DEFAULT = 16;
   localparam int DEPTH_MAX     = 64;

   // field widths
   localparam int CMD_W    = 2;
   localparam int POS_W    = 4;
   localparam int VAL_W    = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // index width on the cell control bus, wide enough for any legal depth
   localparam int IDX_W = $clog2(DEPTH_MAX);

   // command codes
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd3;

   // per-cycle operation broadcast to every cell
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_UPDATE,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic [IDX_W-1:0]   idx;   // target index, or last valid index on rotate
      logic [VAL_W-1:0]   data;  // value to write, or head entry on rotate
   } cell_ctl_type;

endpackage

// File: sv/oaid_if.sv
// oaid_if: request and response channel interfaces (valid/ready handshake)
// depends on oaid_pkg for field widths
`timescale 1ns / 1ps

interface oaid_req_if
   import oaid_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        command;
   logic [POS_W-1:0]        position;
   logic signed [VAL_W-1:0] value;

   modport source (output valid, output command, output position, output value,
                   input ready);
   modport sink   (input valid, input command, input position, input value,
                   output ready);
endinterface

interface oaid_rsp_if
   import oaid_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [STATUS_W-1:0]     status;
   logic [POS_W-1:0]        position_res;
   logic signed [VAL_W-1:0] value_res;
   logic [COUNT_W-1:0]      count;
   logic                    last;

   modport source (output valid, output status, output position_res,
                   output value_res, output count, output last, input ready);
   modport sink   (input valid, input status, input position_res,
                   input value_res, input count, input last, output ready);
endinterface

// File: sv/ordered_array_insert_delete.sv
// ordered_array_insert_delete: top level, command decode and a row of oaid_cell
// depends on oaid_pkg, oaid_if.sv and oaid_cell.sv
`timescale 1ns / 1ps

// Ordered list of up to DEPTH signed 32-bit entries held in a row of cells,
// one entry per cell. Insert, update and delete each take one request, act
// on all cells in the same cycle (insert shifts the entries at and above the
// index up, delete shifts the entries above it down) and return one
// response with the new count. Read-all returns one response per stored
// entry, one per cycle while the response side keeps taking them, with last
// set on the final one; the list streams out of cell 0 while the row rotates,
// so after count rotations it stands back in its original order. A command that
// cannot be carried out (full, empty, index out of range) changes nothing
// and returns a single error response. Timing: insert, update and delete
// take one request per cycle as long as responses are taken; read-all first
// enters its read state, and no new request is taken until its last response
// is registered. The entry storage is not reset; only the fill count and the
// control state are.

module ordered_array_insert_delete
   import oaid_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   oaid_req_if.sink    req_ch,
   oaid_rsp_if.source  rsp_ch
);

   // widths that follow from the capacity
   localparam int FW   = $clog2(DEPTH + 1);              // fill count
   localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1; // read index
   localparam int CW_A = (FW > COUNT_W) ? FW : COUNT_W;
   localparam int CW   = (CW_A > IDX_W) ? CW_A : IDX_W;  // common compare width

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   // control and response registers
   state_type               state_ff, state_in;
   logic [FW-1:0]           fill_ff, fill_in;
   logic [IW-1:0]           rd_idx_ff, rd_idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]        rsp_pos_ff, rsp_pos_in;
   logic [VAL_W-1:0]        rsp_value_ff, rsp_value_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                    rsp_last_ff, rsp_last_in;

   // cell row
   cell_ctl_type            ctl;
   logic [VAL_W-1:0]        cell_entry [DEPTH];

   // decode helpers
   logic                    out_free;
   logic                    accept;
   logic                    rsp_load;
   logic [CW-1:0]           pos_ext;
   logic [CW-1:0]           fill_ext;
   logic [CW-1:0]           fill_in_ext;
   logic [CW-1:0]           rd_idx_ext;
   logic [CW-1:0]           last_idx_ext;
   logic                    is_full;
   logic                    is_empty;

   // response slot can take a new result when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE) && out_free;
   assign accept = req_ch.valid && req_ch.ready;

   assign pos_ext      = CW'(req_ch.position);
   assign fill_ext     = CW'(fill_ff);
   assign rd_idx_ext   = CW'(rd_idx_ff);
   assign last_idx_ext = fill_ext - CW'(1);
   assign is_full      = (fill_ff == FW'(DEPTH));
   assign is_empty     = (fill_ff == '0);

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      rd_idx_in     = rd_idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_load      = 1'b0;
      ctl.op        = CELL_HOLD;
      ctl.idx       = '0;
      ctl.data      = '0;

      // response taken this cycle
      if (rsp_valid_ff && rsp_ch.ready) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // single-response commands report status with zero payload
               rsp_status_in = ST_OK;
               rsp_pos_in    = '0;
               rsp_value_in  = '0;
               rsp_last_in   = 1'b1;
               case (req_ch.command)
                  CMD_INSERT: begin
                     rsp_load = 1'b1;
                     if (is_full) begin
                        rsp_status_in = ST_FULL;
                     end else if (pos_ext > fill_ext) begin
                        rsp_status_in = ST_BADIDX;
                     end else begin
                        ctl.op   = CELL_INSERT;
                        ctl.idx  = IDX_W'(req_ch.position);
                        ctl.data = req_ch.value;
                        fill_in  = fill_ff + FW'(1);
                     end
                  end
                  CMD_READ: begin
                     if (is_empty) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        // start streaming from cell 0
                        state_in  = S_READ;
                        rd_idx_in = '0;
                     end
                  end
                  CMD_UPDATE: begin
                     rsp_load = 1'b1;
                     if (is_empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else if (pos_ext >= fill_ext) begin
                        rsp_status_in = ST_BADIDX;
                     end else begin
                        ctl.op   = CELL_UPDATE;
                        ctl.idx  = IDX_W'(req_ch.position);
                        ctl.data = req_ch.value;
                     end
                  end
                  CMD_DELETE: begin
                     rsp_load = 1'b1;
                     if (is_empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else if (pos_ext >= fill_ext) begin
                        rsp_status_in = ST_BADIDX;
                     end else begin
                        ctl.op  = CELL_DELETE;
                        ctl.idx = IDX_W'(req_ch.position);
                        fill_in = fill_ff - FW'(1);
                     end
                  end
                  default: rsp_load = 1'b0;
               endcase
            end
         end
         S_READ: begin
            if (out_free) begin
               // report the head entry, then rotate the valid part of the row
               rsp_load      = 1'b1;
               rsp_status_in = ST_OK;
               rsp_pos_in    = rd_idx_ext[POS_W-1:0];
               rsp_value_in  = cell_entry[0];
               rsp_last_in   = (rd_idx_ext == last_idx_ext);
               ctl.op        = CELL_ROTATE;
               ctl.idx       = last_idx_ext[IDX_W-1:0];
               ctl.data      = cell_entry[0];
               if (rd_idx_ext == last_idx_ext) begin
                  state_in = S_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff + IW'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      // count reported is the fill after this command
      fill_in_ext = CW'(fill_in);
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = fill_in_ext[COUNT_W-1:0];
      end
   end

   // state and registered response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.position_res = rsp_pos_ff;
   assign rsp_ch.value_res    = rsp_value_ff;
   assign rsp_ch.count        = rsp_count_ff;
   assign rsp_ch.last         = rsp_last_ff;

   // row of cells, each wired to its neighbors; the ends see zero
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic [VAL_W-1:0] left_data;
      logic [VAL_W-1:0] right_data;

      if (k == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_mid_l
         assign left_data = cell_entry[k-1];
      end

      if (k == DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_mid_r
         assign right_data = cell_entry[k+1];
      end

      oaid_cell #(
         .INDEX (k)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .left_data  (left_data),
         .right_data (right_data),
         .entry      (cell_entry[k])
      );
   end

endmodule

// File: sv/oaid_cell.sv
// oaid_cell: one list entry; shifts, loads or rotates on the broadcast control
// depends on oaid_pkg
`timescale 1ns / 1ps

module oaid_cell
   import oaid_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic [VAL_W-1:0]   left_data,   // entry of the cell below
   input  logic [VAL_W-1:0]   right_data,  // entry of the cell above
   output logic [VAL_W-1:0]   entry
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [VAL_W-1:0] entry_ff;
   logic [VAL_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      case (ctl.op)
         CELL_INSERT: begin
            if (MY_IDX > ctl.idx) entry_in = left_data;
            else if (MY_IDX == ctl.idx) entry_in = ctl.data;
         end
         CELL_UPDATE: begin
            if (MY_IDX == ctl.idx) entry_in = ctl.data;
         end
         CELL_DELETE: begin
            if (MY_IDX >= ctl.idx) entry_in = right_data;
         end
         CELL_ROTATE: begin
            // head wraps around to the last valid slot
            if (MY_IDX == ctl.idx) entry_in = ctl.data;
            else entry_in = right_data;
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// File: sim/oaid_checker.sv
// oaid_checker: watches the request and response channels of the list block,
// predicts every response and compares it field by field; needs oaid_pkg, oaid_if.sv
`timescale 1ns / 1ps

module oaid_checker
   import oaid_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   oaid_req_if  req_ch,
   oaid_rsp_if  rsp_ch,
   output int   error_count,
   output int   pending_count
);

   typedef struct {
      logic [STATUS_W-1:0]     status;
      logic [POS_W-1:0]        position_res;
      logic signed [VAL_W-1:0] value_res;
      logic [COUNT_W-1:0]      count;
      logic                    last;
   } rsp_item_type;

   // private copy of the list
   logic signed [VAL_W-1:0] list_mem [DEPTH];
   int unsigned             list_fill;

   rsp_item_type due_rsp_q [$];
   int           fail_tally = 0;

   function automatic void push_rsp(input logic [STATUS_W-1:0] status,
                                    input int unsigned pos,
                                    input logic signed [VAL_W-1:0] val,
                                    input logic last);
      rsp_item_type item;
      item.status       = status;
      item.position_res = POS_W'(pos);
      item.value_res    = val;
      item.count        = COUNT_W'(list_fill);
      item.last         = last;
      due_rsp_q.push_back(item);
   endfunction

   task automatic apply_command(input logic [CMD_W-1:0] cmd,
                                input logic [POS_W-1:0] pos,
                                input logic signed [VAL_W-1:0] val);
      int unsigned i;
      case (cmd)
         CMD_INSERT: begin
            if (list_fill >= DEPTH) begin
               push_rsp(ST_FULL, 0, '0, 1'b1);
            end else if (pos > list_fill) begin
               push_rsp(ST_BADIDX, 0, '0, 1'b1);
            end else begin
               for (i = list_fill; i > pos; i--) list_mem[i] = list_mem[i-1];
               list_mem[pos] = val;
               list_fill++;
               push_rsp(ST_OK, 0, '0, 1'b1);
            end
         end
         CMD_READ: begin
            if (list_fill == 0) begin
               push_rsp(ST_EMPTY, 0, '0, 1'b1);
            end else begin
               for (i = 0; i < list_fill; i++)
                  push_rsp(ST_OK, i, list_mem[i], i + 1 == list_fill);
            end
         end
         CMD_UPDATE: begin
            if (list_fill == 0) begin
               push_rsp(ST_EMPTY, 0, '0, 1'b1);
            end else if (pos >= list_fill) begin
               push_rsp(ST_BADIDX, 0, '0, 1'b1);
            end else begin
               list_mem[pos] = val;
               push_rsp(ST_OK, 0, '0, 1'b1);
            end
         end
         default: begin
            if (list_fill == 0) begin
               push_rsp(ST_EMPTY, 0, '0, 1'b1);
            end else if (pos >= list_fill) begin
               push_rsp(ST_BADIDX, 0, '0, 1'b1);
            end else begin
               for (i = pos; i + 1 < list_fill; i++) list_mem[i] = list_mem[i+1];
               list_fill--;
               push_rsp(ST_OK, 0, '0, 1'b1);
            end
         end
      endcase
   endtask

   function automatic bit field_ok(input string name, input logic [VAL_W-1:0] want,
                                   input logic [VAL_W-1:0] got);
      if (want === got) return 1'b1;
      $display("%0t ns: response %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, name, want, got);
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      bit           good;
      if (reset) begin
         list_fill = 0;
         due_rsp_q.delete();
      end else begin
         // request first so a same-cycle response would still find it queued
         if (req_ch.valid && req_ch.ready)
            apply_command(req_ch.command, req_ch.position, req_ch.value);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due_rsp_q.size() == 0) begin
               fail_tally++;
               $display("%0t ns: unexpected response, expected none, actual status %0d",
                        $time, rsp_ch.status);
            end else begin
               want = due_rsp_q.pop_front();
               good = 1'b1;
               good &= field_ok("status", VAL_W'(want.status), VAL_W'(rsp_ch.status));
               good &= field_ok("position_res", VAL_W'(want.position_res),
                                VAL_W'(rsp_ch.position_res));
               good &= field_ok("value_res", want.value_res, rsp_ch.value_res);
               good &= field_ok("count", VAL_W'(want.count), VAL_W'(rsp_ch.count));
               good &= field_ok("last", VAL_W'(want.last), VAL_W'(rsp_ch.last));
               if (!good) fail_tally++;
            end
         end
      end
      error_count   <= fail_tally;
      pending_count <= due_rsp_q.size();
   end

endmodule

// File: sim/tb_ordered_array_insert_delete.sv
// tb_ordered_array_insert_delete: drives directed and random requests into the
// list block with random idling and gives the verdict; needs oaid_pkg, oaid_if.sv, oaid_checker.sv
`timescale 1ns / 1ps

module tb_ordered_array_insert_delete;
   import oaid_pkg::*;

   localparam int DEPTH       = DEPTH_DEFAULT;
   localparam int RANDOM_REQS = 470;
   localparam int QUIET_LIMIT = 2000;  // cycles with no handshake at all
   localparam int DRAIN_WAIT  = 24;    // settle time once nothing is pending
   localparam int IDLE_PCT    = 18;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // idling on both sides, switched off for one long stretch
   bit idle_on = 1'b1;

   // length of the list as the stimulus sees it, only for picking positions
   int shadow_len = 0;

   int error_count;
   int pending_count;

   oaid_req_if req_ch ();
   oaid_rsp_if rsp_ch ();

   ordered_array_insert_delete #(
      .DEPTH (DEPTH)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   oaid_checker #(
      .DEPTH (DEPTH)
   ) chk (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always #4 clock = ~clock;

   // response side: known from time zero, then stall at random once per falling edge
   initial begin : rsp_side
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
      end
   end

   // one request: optional idle cycles, then hold until the block takes it
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                               input logic signed [VAL_W-1:0] val);
      @(negedge clock);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.command  <= cmd;
      req_ch.position <= pos;
      req_ch.value    <= val;
      do @(posedge clock); while (!req_ch.ready);
      // track the length so random positions stay mostly in range
      if (cmd == CMD_INSERT && shadow_len < DEPTH && pos <= shadow_len) shadow_len++;
      if (cmd == CMD_DELETE && shadow_len > 0 && pos < shadow_len) shadow_len--;
   endtask

   // random content: mostly in-range positions, a share of extreme values
   task automatic send_random(input int mode);
      logic [CMD_W-1:0]        cmd;
      logic [POS_W-1:0]        pos;
      logic signed [VAL_W-1:0] val;
      int                      pick;
      int                      top_pos;
      pick = $urandom_range(99);
      case (mode)
         0: begin // grow toward full
            if (pick < 60) cmd = CMD_INSERT;
            else if (pick < 70) cmd = CMD_READ;
            else if (pick < 85) cmd = CMD_UPDATE;
            else cmd = CMD_DELETE;
         end
         1: begin // drain toward empty
            if (pick < 25) cmd = CMD_INSERT;
            else if (pick < 35) cmd = CMD_READ;
            else if (pick < 50) cmd = CMD_UPDATE;
            else cmd = CMD_DELETE;
         end
         default: begin
            if (pick < 35) cmd = CMD_INSERT;
            else if (pick < 50) cmd = CMD_READ;
            else if (pick < 70) cmd = CMD_UPDATE;
            else cmd = CMD_DELETE;
         end
      endcase
      // legal range: insert may append, update and delete must hit an entry
      top_pos = (cmd == CMD_INSERT) ? shadow_len : shadow_len - 1;
      if (top_pos > DEPTH - 1) top_pos = DEPTH - 1;
      if ($urandom_range(99) < 85 && top_pos >= 0) pos = POS_W'($urandom_range(top_pos, 0));
      else pos = POS_W'($urandom_range(DEPTH - 1, 0));
      case ($urandom_range(19))
         0:       val = 32'sh8000_0000;
         1:       val = 32'sh7fff_ffff;
         2:       val = '0;
         3:       val = -32'sd1;
         default: val = $urandom;
      endcase
      send_request(cmd, pos, val);
   endtask

   // watchdog: any stretch with no handshake on either side is a hang
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      int n;
      // all request inputs known from time zero
      req_ch.valid    = 1'b0;
      req_ch.command  = CMD_READ;
      req_ch.position = '0;
      req_ch.value    = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty list: every command fails, including an insert past the end
      send_request(CMD_READ, 4'd0, 32'sd0);
      send_request(CMD_UPDATE, 4'd0, 32'sd7);
      send_request(CMD_DELETE, 4'd0, 32'sd0);
      send_request(CMD_INSERT, 4'd15, 32'sd1);
      // first insert at 0, then append, insert in front, append again
      send_request(CMD_INSERT, 4'd0, 32'sh8000_0000);
      send_request(CMD_INSERT, 4'd1, 32'sh7fff_ffff);
      send_request(CMD_INSERT, 4'd0, 32'sd0);
      send_request(CMD_INSERT, 4'd3, -32'sd1);
      // index beyond count on insert and update
      send_request(CMD_INSERT, 4'd15, 32'sd5);
      send_request(CMD_UPDATE, 4'd1, 32'sh5a5a_5a5a);
      send_request(CMD_UPDATE, 4'd4, 32'sd9);
      send_request(CMD_UPDATE, 4'd15, 32'sd9);
      send_request(CMD_READ, 4'd0, 32'sd0);
      // delete out of range, in the middle, at the top, then down to empty
      send_request(CMD_DELETE, 4'd15, 32'sd0);
      send_request(CMD_DELETE, 4'd4, 32'sd0);
      send_request(CMD_DELETE, 4'd1, 32'sd0);
      send_request(CMD_DELETE, 4'd2, 32'sd0);
      send_request(CMD_READ, 4'd0, 32'sd0);
      send_request(CMD_DELETE, 4'd0, 32'sd0);
      send_request(CMD_DELETE, 4'd0, 32'sd0);
      send_request(CMD_READ, 4'd0, 32'sd0);
      send_request(CMD_INSERT, 4'd1, 32'sd3);

      // random part: grow, drain and mix phases so the list goes full and empty
      for (n = 0; n < RANDOM_REQS; n++) begin
         idle_on = !(n >= 180 && n < 300);
         send_random((n / 50) % 3);
      end
      idle_on = 1'b1;

      @(negedge clock);
      req_ch.valid <= 1'b0;

      // let every queued response come out, then a little settle time
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (error_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: ordered_array_insert_delete.f
sv/oaid_pkg.sv
sv/oaid_if.sv
sv/oaid_cell.sv
sv/ordered_array_insert_delete.sv
sim/oaid_checker.sv
sim/tb_ordered_array_insert_delete.sv
